// File: design/bc_pkg.sv
`timescale 1ns / 1ps

package bc_pkg;

  // field widths
  localparam int unsigned NW = 6;
  localparam int unsigned VW = 31;
  // product of a value and a 6-bit factor
  localparam int unsigned PW = VW + NW;
  localparam int unsigned CW = $clog2(PW);

  localparam int unsigned MAX_N_DEF = 63;
  localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

  typedef struct packed {
    logic [NW-1:0] n;
    logic [NW-1:0] k;
  } in_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          overflow;
    logic          k_above_n;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic k_above;
    logic k_zero;
    logic div_last;
    logic over;
    logic last;
  } sts_t;

endpackage

// File: design/binomial_coefficient.sv
`timescale 1ns / 1ps

// Computes C(n,k) for 6-bit n and k, one item at a time. k is first reduced to
// min(k, n-k); each of those steps is one multiply, a pass of the bit-serial
// restoring divider in the datapath and one update, with setup and handoff
// states around the steps. Work stops early once the running value passes
// 2^31-1: the result then saturates with overflow set. k above n gives value
// 0 with k_above_n set. n above MaxN is clamped to MaxN. A finished result
// sits in the output register while the next item is accepted.
module binomial_coefficient #(
  parameter int unsigned MaxN = bc_pkg::MAX_N_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bc_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bc_pkg::out_t  out_data_o
);

  bc_pkg::cmd_t cmd;
  bc_pkg::sts_t sts;
  bc_pkg::out_t result;
  logic         out_load;
  logic         out_free;
  logic         out_valid_q, out_valid_d;
  bc_pkg::out_t out_data_q;

  assign out_free = ~out_valid_q | out_ready_i;

  bc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bc_datapath #(
    .MaxN (MaxN)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_k_above_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.k_above_n |-> out_data_o.value == '0 && !out_data_o.overflow)
    else $error("k above n result not zero");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.value == bc_pkg::VALUE_MAX)
    else $error("overflow result not saturated");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before taken");

endmodule

// File: design/bc_datapath.sv
`timescale 1ns / 1ps

module bc_datapath #(
  parameter int unsigned MaxN = bc_pkg::MAX_N_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bc_pkg::in_t   in_data_i,
  input  bc_pkg::cmd_t  cmd_i,
  output bc_pkg::sts_t  sts_o,
  output bc_pkg::out_t  result_o
);

  localparam int unsigned NW = bc_pkg::NW;
  localparam int unsigned VW = bc_pkg::VW;
  localparam int unsigned PW = bc_pkg::PW;
  localparam int unsigned CW = bc_pkg::CW;

  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] kr_q, kr_d;
  logic [NW-1:0] i_q, i_d;
  logic [VW-1:0] acc_q, acc_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          kab_q, kab_d;
  logic          ovf_q, ovf_d;

  logic [NW-1:0] n_c;
  logic [NW-1:0] n_minus_k;
  logic [NW-1:0] divisor;
  logic [NW:0]   rem_sh;
  logic [NW:0]   rem_sub;
  logic          q_bit;
  logic [NW-1:0] factor;
  logic          quo_over;

  always_comb begin
    n_c = in_data_i.n;
    if (32'(in_data_i.n) > MaxN) begin
      n_c = NW'(MaxN);
    end
    n_minus_k = n_c - in_data_i.k;
  end

  assign divisor  = i_q + NW'(1);
  assign factor   = n_q - i_q;
  assign rem_sh   = {rem_q, quo_q[PW-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign quo_over = |quo_q[PW-1:VW];

  always_comb begin
    n_d   = n_q;
    kr_d  = kr_q;
    i_d   = i_q;
    acc_d = acc_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    kab_d = kab_q;
    ovf_d = ovf_q;
    if (cmd_i.load) begin
      n_d   = n_c;
      kab_d = (in_data_i.k > n_c);
      kr_d  = (in_data_i.k > n_minus_k) ? n_minus_k : in_data_i.k;
      i_d   = '0;
      acc_d = VW'(1);
      ovf_d = 1'b0;
    end
    if (cmd_i.mul) begin
      quo_d = PW'(acc_q) * PW'(factor);
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.div) begin
      // restoring division, one quotient bit per cycle
      quo_d = {quo_q[PW-2:0], q_bit};
      rem_d = q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.update) begin
      acc_d = quo_q[VW-1:0];
      i_d   = i_q + NW'(1);
      ovf_d = quo_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      kr_q  <= '0;
      i_q   <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      kab_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      n_q   <= n_d;
      kr_q  <= kr_d;
      i_q   <= i_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      kab_q <= kab_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign sts_o.k_above  = kab_q;
  assign sts_o.k_zero   = (kr_q == '0);
  assign sts_o.div_last = (cnt_q == CW'(PW - 1));
  assign sts_o.over     = quo_over;
  assign sts_o.last     = ((i_q + NW'(1)) == kr_q);

  always_comb begin
    result_o.k_above_n = kab_q;
    result_o.overflow  = ovf_q & ~kab_q;
    if (kab_q) begin
      result_o.value = '0;
    end else if (ovf_q) begin
      result_o.value = bc_pkg::VALUE_MAX;
    end else begin
      result_o.value = acc_q;
    end
  end

endmodule

// File: design/bc_ctrl.sv
`timescale 1ns / 1ps

module bc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  output logic          out_load_o,
  input  bc_pkg::sts_t  sts_i,
  output bc_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_CHK   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.k_above || sts_i.k_zero) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd_o.update = 1'b1;
        // coefficient only grows from here, so stop on overflow
        if (sts_i.over || sts_i.last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DRAIN_CYCLES = 1500;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RAND_PER_PHASE = 66;
  localparam int unsigned NUM_PHASES = 4;

  class coeff_scoreboard;
    bc_pkg::out_t expected_coeffs[$];
    int unsigned  errors = 0;

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // multiplicative form, stopping as soon as the running value saturates
    function bc_pkg::out_t binom_of(bc_pkg::in_t it);
      logic [63:0]  acc;
      int unsigned  nn;
      int unsigned  kk;
      bc_pkg::out_t r;
      nn = it.n;
      kk = it.k;
      r  = '0;
      if (nn > bc_pkg::MAX_N_DEF) nn = bc_pkg::MAX_N_DEF;
      if (kk > nn) begin
        r.k_above_n = 1'b1;
        return r;
      end
      if (kk > nn - kk) kk = nn - kk;
      acc = 64'd1;
      for (int unsigned i = 0; i < kk; i++) begin
        acc = acc * 64'(nn - i);
        acc = acc / 64'(i + 1);
        if (acc > 64'(bc_pkg::VALUE_MAX)) begin
          r.value    = bc_pkg::VALUE_MAX;
          r.overflow = 1'b1;
          return r;
        end
      end
      r.value = acc[bc_pkg::VW-1:0];
      return r;
    endfunction

    function void note_item(bc_pkg::in_t it);
      expected_coeffs = {expected_coeffs, binom_of(it)};
    endfunction

    function int unsigned pending();
      return expected_coeffs.size();
    endfunction

    task check_item(bc_pkg::out_t got);
      bc_pkg::out_t exp;
      if (expected_coeffs.size() == 0) begin
        report($sformatf("unexpected result value=%0d ovf=%0b kan=%0b",
                         got.value, got.overflow, got.k_above_n));
        return;
      end
      exp = expected_coeffs.pop_front();
      if (got.value !== exp.value)
        report($sformatf("value got %0d exp %0d", got.value, exp.value));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow got %0b exp %0b", got.overflow, exp.overflow));
      if (got.k_above_n !== exp.k_above_n)
        report($sformatf("k_above_n got %0b exp %0b", got.k_above_n, exp.k_above_n));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bc_pkg::out_t out_data;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  coeff_scoreboard sb = new();

  // k above n, trivial k, exact fits and first overflows near 2^31
  bc_pkg::in_t directed_cases [17] = '{
    '{6'd0, 6'd0},   '{6'd63, 6'd63}, '{6'd0, 6'd63},  '{6'd5, 6'd6},
    '{6'd62, 6'd63}, '{6'd1, 6'd0},   '{6'd1, 6'd1},   '{6'd10, 6'd0},
    '{6'd10, 6'd10}, '{6'd63, 6'd1},  '{6'd63, 6'd62}, '{6'd33, 6'd16},
    '{6'd34, 6'd17}, '{6'd63, 6'd31}, '{6'd63, 6'd32}, '{6'd31, 6'd15},
    '{6'd34, 6'd16}
  };

  binomial_coefficient uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_item(bc_pkg::in_t d);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_item(d);
  endtask

  function automatic bc_pkg::in_t random_item();
    bc_pkg::in_t it;
    if ($urandom_range(99) < 15) begin
      it.n = 6'($urandom_range(62));
      it.k = 6'($urandom_range(63, int'(it.n) + 1));
    end else begin
      it.n = 6'($urandom_range(63));
      it.k = 6'($urandom_range(int'(it.n)));
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_item(out_data);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL binomial_coefficient");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_cases[i]) send_item(directed_cases[i]);
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (RAND_PER_PHASE) send_item(random_item());
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS binomial_coefficient");
    else
      $display("FAIL binomial_coefficient");
    $finish;
  end

endmodule
